FILE: hdl/mexp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared types and constants of the modular exponentiation core.
// ----------------------------------------------------------------------------
package mexp_pkg;

    localparam int DATA_W        = 32;
    localparam int WIDTH_DEFAULT = 32;
    localparam int CFG_IDX_W     = 1;

    localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 1'd1;

    // control of the cell row: clear, step and add
    typedef struct packed {
        logic clr;
        logic step;
        logic add;
    } mexp_ctrl_t;

    // reduction choice shared by every cell
    typedef struct packed {
        logic sub1;
        logic sub2;
    } mexp_sel_t;

endpackage

FILE: hdl/modular_exponentiation_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_exponentiation_core
// message ^ exponent mod modulus by left-to-right square-and-multiply.
// ----------------------------------------------------------------------------
// One message word at a time. The message is first reduced modulo the modulus
// by one pass of the product unit, then every exponent bit below the top one
// costs a squaring and, for a one bit, a multiply by the message. Each pass
// runs WIDTH steps on a row of WIDTH+2 bit cells. A zero modulus gives 0
// without any pass. The result sits in an output register, so the next word
// is taken while it waits. Write modulus and exponent only while idle.
module modular_exponentiation_core #(
    parameter int WIDTH = mexp_pkg::WIDTH_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [mexp_pkg::DATA_W-1:0]   s_tdata,   // [31:0] message
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mexp_pkg::DATA_W-1:0]   m_tdata,   // [31:0] power_mod
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mexp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mexp_pkg::DATA_W-1:0]   cfg_data
);
    import mexp_pkg::*;

    localparam int RW = WIDTH + 2;
    localparam int CW = $clog2(WIDTH);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_NEXT = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    typedef enum logic [2:0] {
        PH_RED = 3'b001,
        PH_SQR = 3'b010,
        PH_PRD = 3'b100
    } phase_t;

    state_t            state_reg, state_next;
    phase_t            phase_reg, phase_next;
    logic [DATA_W-1:0] modulus_reg, modulus_next, exponent_reg, exponent_next;
    logic [WIDTH-1:0]  n_reg, n_next, e_reg, e_next, m_reg, m_next;
    logic [WIDTH-1:0]  a_reg, a_next, b_reg, b_next;
    logic [CW-1:0]     mcnt_reg, mcnt_next, ecnt_reg, ecnt_next;
    logic [DATA_W-1:0] res_reg, res_next, out_reg, out_next;
    logic              outv_reg, outv_next;
    mexp_ctrl_t        ctrl;
    logic [RW-1:0]     r_val;
    logic [WIDTH-1:0]  r_w, c0;
    logic              launch;

    mexp_chain #(.WIDTH(WIDTH)) u_chain (
        .aclk  (aclk),
        .ctrl  (ctrl),
        .b_val (b_reg),
        .n_val (n_reg),
        .r_val (r_val)
    );

    assign r_w       = r_val[WIDTH-1:0];
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = outv_reg;
    assign m_tdata   = out_reg;
    assign cfg_ready = 1'b1;

    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        modulus_next  = modulus_reg;
        exponent_next = exponent_reg;
        n_next        = n_reg;
        e_next        = e_reg;
        m_next        = m_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        mcnt_next     = mcnt_reg;
        ecnt_next     = ecnt_reg;
        res_next      = res_reg;
        out_next      = out_reg;
        outv_next     = outv_reg;
        launch        = 1'b0;
        ctrl.step     = 1'b0;
        ctrl.add      = 1'b0;
        c0            = e_reg[WIDTH-1] ? r_w : WIDTH'(1);

        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_MODULUS:  modulus_next  = cfg_data;
                REG_EXPONENT: exponent_next = cfg_data;
                default: ;
            endcase
        end

        if (outv_reg && m_tready) begin
            outv_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    n_next = WIDTH'(modulus_reg);
                    e_next = WIDTH'(exponent_reg);
                    if (WIDTH'(modulus_reg) == '0) begin
                        res_next   = '0;
                        state_next = ST_FIN;
                    end else begin
                        // message mod n as the product message * 1
                        a_next     = WIDTH'(s_tdata);
                        b_next     = WIDTH'(1);
                        phase_next = PH_RED;
                        launch     = 1'b1;
                    end
                end
            end
            ST_MUL: begin
                ctrl.step = 1'b1;
                ctrl.add  = a_reg[WIDTH-1];
                a_next    = {a_reg[WIDTH-2:0], 1'b0};
                if (mcnt_reg == '0) begin
                    state_next = ST_NEXT;
                end else begin
                    mcnt_next = mcnt_reg - 1'b1;
                end
            end
            ST_NEXT: begin
                case (phase_reg)
                    PH_RED: begin
                        m_next     = r_w;
                        a_next     = c0;
                        b_next     = c0;
                        e_next     = {e_reg[WIDTH-2:0], 1'b0};
                        ecnt_next  = CW'(WIDTH - 1);
                        phase_next = PH_SQR;
                        launch     = 1'b1;
                    end
                    PH_SQR: begin
                        if (e_reg[WIDTH-1]) begin
                            a_next     = r_w;
                            b_next     = m_reg;
                            phase_next = PH_PRD;
                            launch     = 1'b1;
                        end else if (ecnt_reg == CW'(1)) begin
                            res_next   = DATA_W'(r_w);
                            state_next = ST_FIN;
                        end else begin
                            e_next     = {e_reg[WIDTH-2:0], 1'b0};
                            ecnt_next  = ecnt_reg - 1'b1;
                            a_next     = r_w;
                            b_next     = r_w;
                            launch     = 1'b1;
                        end
                    end
                    PH_PRD: begin
                        if (ecnt_reg == CW'(1)) begin
                            res_next   = DATA_W'(r_w);
                            state_next = ST_FIN;
                        end else begin
                            e_next     = {e_reg[WIDTH-2:0], 1'b0};
                            ecnt_next  = ecnt_reg - 1'b1;
                            a_next     = r_w;
                            b_next     = r_w;
                            phase_next = PH_SQR;
                            launch     = 1'b1;
                        end
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_FIN: begin
                if (!outv_reg || m_tready) begin
                    out_next   = res_reg;
                    outv_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (launch) begin
            mcnt_next  = CW'(WIDTH - 1);
            state_next = ST_MUL;
        end
        ctrl.clr = launch;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            phase_reg    <= PH_RED;
            modulus_reg  <= DATA_W'(1);
            exponent_reg <= '0;
            outv_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            modulus_reg  <= modulus_next;
            exponent_reg <= exponent_next;
            outv_reg     <= outv_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg    <= n_next;
        e_reg    <= e_next;
        m_reg    <= m_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        mcnt_reg <= mcnt_next;
        ecnt_reg <= ecnt_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

endmodule

FILE: hdl/mexp_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_cell
// One bit slice of the Blakley product register: doubling, add and the two
// candidate subtractions of the modulus and of twice the modulus.
// ----------------------------------------------------------------------------
module mexp_cell (
    input  logic               aclk,
    input  logic               r_in,
    input  logic               b_bit,
    input  logic               n_bit,
    input  logic               n2_bit,
    input  logic               cs_in,
    input  logic               c1_in,
    input  logic               c2_in,
    input  mexp_pkg::mexp_ctrl_t ctrl,
    input  mexp_pkg::mexp_sel_t  sel,
    output logic               cs_out,
    output logic               c1_out,
    output logic               c2_out,
    output logic               r_out
);
    import mexp_pkg::*;

    logic r_reg, r_next;
    logic addend, s_bit, d1_bit, d2_bit;

    always_comb begin
        // r_in is the lower neighbor's bit, so this is 2R
        addend = ctrl.add & b_bit;
        s_bit  = r_in ^ addend ^ cs_in;
        cs_out = (r_in & addend) | (r_in & cs_in) | (addend & cs_in);
        d1_bit = s_bit ^ ~n_bit ^ c1_in;
        c1_out = (s_bit & ~n_bit) | (s_bit & c1_in) | (~n_bit & c1_in);
        d2_bit = s_bit ^ ~n2_bit ^ c2_in;
        c2_out = (s_bit & ~n2_bit) | (s_bit & c2_in) | (~n2_bit & c2_in);
        r_next = r_reg;
        if (ctrl.clr) begin
            r_next = 1'b0;
        end else if (ctrl.step) begin
            if (sel.sub2) begin
                r_next = d2_bit;
            end else if (sel.sub1) begin
                r_next = d1_bit;
            end else begin
                r_next = s_bit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        r_reg <= r_next;
    end

    assign r_out = r_reg;

endmodule

FILE: hdl/mexp_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_chain
// Row of WIDTH+2 bit cells forming the Blakley modular product unit.
// ----------------------------------------------------------------------------
module mexp_chain #(
    parameter int WIDTH = mexp_pkg::WIDTH_DEFAULT
) (
    input  logic               aclk,
    input  mexp_pkg::mexp_ctrl_t ctrl,
    input  logic [WIDTH-1:0]   b_val,
    input  logic [WIDTH-1:0]   n_val,
    output logic [WIDTH+1:0]   r_val
);
    import mexp_pkg::*;

    localparam int RW = WIDTH + 2;

    logic [RW-1:0] b_ext, n_ext, n2_ext, r_sh;
    logic [RW:0]   cs, c1, c2;
    mexp_sel_t     sel;

    assign b_ext  = RW'(b_val);
    assign n_ext  = RW'(n_val);
    assign n2_ext = {n_ext[RW-2:0], 1'b0};
    assign r_sh   = {r_val[RW-2:0], 1'b0};
    assign cs[0]  = 1'b0;
    assign c1[0]  = 1'b1;
    assign c2[0]  = 1'b1;

    // carry out of the subtract chains means the sum reached n or 2n
    assign sel.sub1 = c1[RW];
    assign sel.sub2 = c2[RW];

    genvar i;
    generate
        for (i = 0; i < RW; i++) begin : g_cell
            mexp_cell u_cell (
                .aclk   (aclk),
                .r_in   (r_sh[i]),
                .b_bit  (b_ext[i]),
                .n_bit  (n_ext[i]),
                .n2_bit (n2_ext[i]),
                .cs_in  (cs[i]),
                .c1_in  (c1[i]),
                .c2_in  (c2[i]),
                .ctrl   (ctrl),
                .sel    (sel),
                .cs_out (cs[i+1]),
                .c1_out (c1[i+1]),
                .c2_out (c2[i+1]),
                .r_out  (r_val[i])
            );
        end
    endgenerate

endmodule

FILE: hdl/mexp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_checker
// Port-level checks of the modular exponentiation core, bound to the top.
// ----------------------------------------------------------------------------
module mexp_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [mexp_pkg::DATA_W-1:0]   m_tdata
);
    import mexp_pkg::*;

    // a stalled result word stays put
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word dropped or changed under stall");

    // one word at a time: busy right after taking a word
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again while busy");

    // no result straight after a take
    a_no_instant: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result appeared one cycle after input");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("bad state after reset");

endmodule

bind modular_exponentiation_core mexp_checker u_mexp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
